// ===== rtl/peac_pkg.sv =====
package peac_pkg;

	localparam int NUM_CH    = 8;
	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE       = 3'd4;

	localparam logic [14:0] THRESHOLD_RST = 15'd23198;
	localparam logic [15:0] RATIO_RST     = 16'd49152;

endpackage

// ===== rtl/peak_envelope_audio_compressor.sv =====
// Per frame: peak scan of the channels, envelope update, gain (a divider giving one
// quotient bit per cycle, only above threshold), wait for a free output slot, then
// scaling. A new frame is taken only once the last one is scaled; one 18x18 multiplier
// is shared by envelope, gain and scaling, and the gain divide uses a 48-bit subtractor.
// Reset (arst_n low, asynchronous): registers at their defaults, envelope zero,
// no output word pending.
module peak_envelope_audio_compressor
	import peac_pkg::*;
#(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_wdata,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// in_ch0 .. in_ch7, 16 bits each
	input  logic [NUM_CH*SAMPLE_W-1:0]   s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// out_ch0 .. out_ch7, 16 bits each, then applied_gain
	output logic [NUM_CH*SAMPLE_W+GAIN_W-1:0] m_axis_tdata
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam logic [3:0] MAX_N = 4'(MAX_CHANNELS);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PEAK   = 4'd1;
	localparam logic [3:0] S_ENV_A  = 4'd2;
	localparam logic [3:0] S_ENV_B  = 4'd3;
	localparam logic [3:0] S_ENV_C  = 4'd4;
	localparam logic [3:0] S_GAIN_A = 4'd5;
	localparam logic [3:0] S_GAIN_B = 4'd6;
	localparam logic [3:0] S_GAIN_C = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_HOLD   = 4'd9;
	localparam logic [3:0] S_APPLY  = 4'd10;

	logic [3:0]  state_q;
	logic [3:0]  cnt_q;
	logic [3:0]  n_q;

	logic [3:0]  chan_count_q;
	logic [14:0] thresh_q;
	logic [15:0] ratio_q;
	logic [15:0] attack_q;
	logic [15:0] release_q;

	sample_t     smp_q [MAX_CHANNELS];
	sample_t     out_q [NUM_CH];
	logic [15:0] gain_out_q;
	logic        out_valid_q;

	logic [14:0] peak_q;
	logic [15:0] env_q;
	logic [31:0] acc_q;
	logic [31:0] den_q;
	logic [47:0] rem_q;
	logic [47:0] dsh_q;
	logic [15:0] quo_q;
	logic [14:0] gain_q;
	logic [15:0] applied_q;

	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [35:0] mul_q;

	logic [IDX_W-1:0] rd_idx;
	sample_t     rd_smp;
	logic [15:0] abs_raw;
	logic [14:0] abs_sat;
	logic [15:0] coef;
	logic [15:0] env_diff;
	logic [32:0] env_sum;
	logic        div_ge;
	logic [15:0] quo_next;
	logic [16:0] applied_sum;
	logic [3:0]  wr_idx;
	logic signed [36:0] rnd_sum;
	logic signed [21:0] rnd_q;
	sample_t     scaled;
	logic        accept;
	logic        out_free;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			m_axis_tdata[i*SAMPLE_W +: SAMPLE_W] = out_q[i];
		end
		m_axis_tdata[NUM_CH*SAMPLE_W +: GAIN_W] = gain_out_q;
	end

	assign rd_idx  = cnt_q[IDX_W-1:0];
	assign rd_smp  = (cnt_q < MAX_N) ? smp_q[rd_idx] : '0;
	assign abs_raw = rd_smp[SAMPLE_W-1] ? (~rd_smp + 16'd1) : rd_smp;
	assign abs_sat = abs_raw[15] ? 15'h7FFF : abs_raw[14:0];

	assign coef     = ({1'b0, peak_q} > env_q) ? attack_q : release_q;
	assign env_diff = env_q - {1'b0, thresh_q};
	assign env_sum  = {1'b0, acc_q} + {1'b0, mul_q[31:0]} + 33'd32768;

	assign div_ge   = (rem_q >= dsh_q);
	assign quo_next = {quo_q[14:0], div_ge};

	assign applied_sum = {2'b0, gain_q} + 17'd32769;

	assign wr_idx  = cnt_q - 4'd1;
	assign rnd_sum = 37'(mul_q) + 37'sd16384;
	assign rnd_q   = rnd_sum[36:15];
	always_comb begin
		if (rnd_q > 22'sd32767) begin
			scaled = SAMPLE_MAX;
		end else if (rnd_q < -22'sd32768) begin
			scaled = SAMPLE_MIN;
		end else begin
			scaled = rnd_q[15:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ENV_A: begin
				mul_a = {2'b0, coef};
				mul_b = {2'b0, env_q};
			end
			S_ENV_B: begin
				mul_a = {1'b0, 17'h10000 - {1'b0, coef}};
				mul_b = {3'b0, peak_q};
			end
			S_GAIN_A: begin
				mul_a = {2'b0, ratio_q};
				mul_b = {2'b0, env_diff};
			end
			S_GAIN_B: begin
				mul_a = {3'b0, thresh_q};
				mul_b = {3'b0, thresh_q};
			end
			S_APPLY: begin
				mul_a = {{2{rd_smp[SAMPLE_W-1]}}, rd_smp};
				mul_b = {2'b0, applied_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= '0;
			thresh_q     <= THRESHOLD_RST;
			ratio_q      <= RATIO_RST;
			attack_q     <= '0;
			release_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT: chan_count_q <= cfg_wdata[3:0];
				REG_THRESHOLD:     thresh_q     <= cfg_wdata[14:0];
				REG_RATIO:         ratio_q      <= cfg_wdata;
				REG_ATTACK:        attack_q     <= cfg_wdata;
				REG_RELEASE:       release_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						for (int i = 0; i < MAX_CHANNELS; i++) begin
							smp_q[i] <= s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
						end
						n_q     <= (chan_count_q > MAX_N) ? MAX_N : chan_count_q;
						cnt_q   <= '0;
						peak_q  <= '0;
						state_q <= S_PEAK;
					end
				end
				S_PEAK: begin
					if (cnt_q < n_q && abs_sat > peak_q) begin
						peak_q <= abs_sat;
					end
					if (cnt_q == MAX_N - 4'd1) begin
						state_q <= S_ENV_A;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_ENV_A: begin
					state_q <= S_ENV_B;
				end
				S_ENV_B: begin
					acc_q   <= mul_q[31:0];
					state_q <= S_ENV_C;
				end
				S_ENV_C: begin
					env_q   <= env_sum[31:16];
					state_q <= S_GAIN_A;
				end
				S_GAIN_A: begin
					if (env_q > {1'b0, thresh_q}) begin
						state_q <= S_GAIN_B;
					end else begin
						gain_q  <= thresh_q;
						state_q <= S_HOLD;
					end
				end
				S_GAIN_B: begin
					den_q   <= {1'b0, thresh_q, 16'b0} + mul_q[31:0];
					state_q <= S_GAIN_C;
				end
				S_GAIN_C: begin
					rem_q <= {2'b0, mul_q[29:0], 16'b0} + {17'b0, den_q[31:1]};
					dsh_q <= {1'b0, den_q, 15'b0};
					quo_q <= '0;
					cnt_q <= 4'd15;
					if (den_q == '0) begin
						gain_q  <= '0;
						state_q <= S_HOLD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - dsh_q;
					end
					dsh_q <= dsh_q >> 1;
					quo_q <= quo_next;
					if (cnt_q == 4'd0) begin
						gain_q  <= quo_next[15] ? 15'h7FFF : quo_next[14:0];
						state_q <= S_HOLD;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				S_HOLD: begin
					applied_q <= applied_sum[16:1];
					if (out_free) begin
						for (int i = 0; i < NUM_CH; i++) begin
							out_q[i] <= '0;
						end
						cnt_q   <= '0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (cnt_q != 4'd0 && wr_idx < n_q) begin
						out_q[wr_idx[2:0]] <= scaled;
					end
					if (cnt_q == MAX_N) begin
						gain_out_q  <= applied_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_PEAK)
		else $error("accepted word did not start the channel scan");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> den_q != '0)
		else $error("divider running with zero divisor");

	a_apply_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |-> !out_valid_q)
		else $error("output registers overwritten while a word is pending");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GAIN_A |-> !env_q[15])
		else $error("envelope above full scale");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> gain_out_q <= 16'd32768)
		else $error("applied gain above unity");

endmodule

// ===== tb/tb.sv =====
module tb;
	import peac_pkg::*;

	localparam int FRAME_W      = NUM_CH*SAMPLE_W;
	localparam int RESULT_W     = NUM_CH*SAMPLE_W + GAIN_W;
	localparam int HOLD_CYCLES  = 400;
	localparam int LIMIT_CYCLES = 400000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [FRAME_W-1:0]     s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [RESULT_W-1:0]    m_axis_tdata;

	// compressor state as seen from outside
	logic [3:0]             chan_cnt;
	logic [14:0]            thresh;
	logic [15:0]            ratio;
	logic [15:0]            attack;
	logic [15:0]            release_c;
	logic [15:0]            env_level;

	logic [RESULT_W-1:0]    pending_frames[$];
	int                     mismatches = 0;
	int                     frames_sent = 0;
	int                     frames_checked = 0;
	int                     settings_used = 0;
	int                     cycle_count = 0;
	bit                     idle_on = 1'b0;
	bit                     hold_request = 1'b0;

	peak_envelope_audio_compressor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("peak_envelope_audio_compressor test failed");
			$finish;
		end
	end

	function automatic logic [RESULT_W-1:0] compress_frame(input logic [FRAME_W-1:0] frame);
		int unsigned           active;
		longint unsigned       peak, mag, coef, env, thr, divisor, num, gain, applied;
		longint                smp, prod, scaled;
		logic [RESULT_W-1:0]   res;
		active = (chan_cnt > NUM_CH) ? NUM_CH : chan_cnt;
		peak = 0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (i < active) begin
				smp = longint'($signed(frame[i*SAMPLE_W +: SAMPLE_W]));
				mag = (smp < 0) ? -smp : smp;
				if (mag > longint'(SAMPLE_MAX))
					mag = longint'(SAMPLE_MAX);
				if (mag > peak)
					peak = mag;
			end
		end
		coef = (peak > env_level) ? attack : release_c;
		env = (coef*env_level + (65536 - coef)*peak + 32768) >> 16;
		env_level = env[15:0];
		thr = thresh;
		if (env > thr) begin
			divisor = thr*65536 + ratio*(env - thr);
			num = (thr*thr) << 16;
			gain = (divisor != 0) ? (num + divisor/2)/divisor : 0;
		end else
			gain = thr;
		if (gain > 32767)
			gain = 32767;
		applied = (gain + 32769) >> 1;
		res = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (i < active) begin
				smp = longint'($signed(frame[i*SAMPLE_W +: SAMPLE_W]));
				prod = smp*longint'(applied) + 16384;
				scaled = prod >>> 15;
				if (scaled > longint'(SAMPLE_MAX))
					scaled = longint'(SAMPLE_MAX);
				if (scaled < longint'(SAMPLE_MIN))
					scaled = longint'(SAMPLE_MIN);
				res[i*SAMPLE_W +: SAMPLE_W] = scaled[SAMPLE_W-1:0];
			end
		end
		res[FRAME_W +: GAIN_W] = applied[GAIN_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_check
		logic [RESULT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_frames.size() == 0)
				report_mismatch("output word with no frame pending");
			else begin
				want = pending_frames.pop_front();
				frames_checked++;
				for (int k = 0; k <= NUM_CH; k++) begin
					if (m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] !== want[k*SAMPLE_W +: SAMPLE_W])
						report_mismatch($sformatf("frame %0d %s: got %h, expected %h",
							frames_checked - 1,
							(k == NUM_CH) ? "applied_gain" : $sformatf("out_ch%0d", k),
							m_axis_tdata[k*SAMPLE_W +: SAMPLE_W],
							want[k*SAMPLE_W +: SAMPLE_W]));
				end
			end
		end
	end

	initial begin : output_ready
		int stall;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 12);
				m_axis_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else
				m_axis_tready <= 1'b1;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CHANNEL_COUNT: chan_cnt = val[3:0];
			REG_THRESHOLD:     thresh = val[14:0];
			REG_RATIO:         ratio = val;
			REG_ATTACK:        attack = val;
			REG_RELEASE:       release_c = val;
			default: ;
		endcase
		settings_used++;
	endtask

	task automatic send_frame(input logic [FRAME_W-1:0] frame);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= frame;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_frames.push_back(compress_frame(frame));
		frames_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	function automatic logic [FRAME_W-1:0] fill_frame(input logic [SAMPLE_W-1:0] v);
		logic [FRAME_W-1:0] f;
		for (int i = 0; i < NUM_CH; i++)
			f[i*SAMPLE_W +: SAMPLE_W] = v;
		return f;
	endfunction

	function automatic logic [FRAME_W-1:0] make_frame(input int unsigned amp);
		logic [FRAME_W-1:0]  f;
		logic [SAMPLE_W-1:0] v;
		for (int i = 0; i < NUM_CH; i++) begin
			case ($urandom_range(0, 15))
				0: v = SAMPLE_W'($urandom());
				1: v = SAMPLE_MIN;
				2: v = SAMPLE_MAX;
				default: begin
					v = SAMPLE_W'($urandom_range(0, amp));
					if ($urandom_range(0, 1))
						v = -v;
				end
			endcase
			f[i*SAMPLE_W +: SAMPLE_W] = v;
		end
		return f;
	endfunction

	function automatic logic [FRAME_W-1:0] noise_frame();
		logic [FRAME_W-1:0] f;
		for (int i = 0; i < NUM_CH; i++)
			f[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom());
		return f;
	endfunction

	// bursts of frames at a steady level so the envelope climbs and decays
	task automatic send_program(input int count);
		int          left, burst;
		int unsigned amp;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > left)
				burst = left;
			case ($urandom_range(0, 3))
				0: amp = $urandom_range(0, (thresh >> 1) + 1);
				1: amp = $urandom_range(thresh >> 1, thresh + (thresh >> 2) + 1);
				default: amp = $urandom_range(thresh, 32767);
			endcase
			if (amp > 32767)
				amp = 32767;
			repeat (burst) begin
				if ($urandom_range(0, 6) == 0)
					send_frame(noise_frame());
				else
					send_frame(make_frame(amp));
			end
			left -= burst;
		end
	endtask

	task automatic test_reset_defaults();
		idle_on = 1'b1;
		send_frame(fill_frame(SAMPLE_MAX));
		send_frame(noise_frame());
		wait_drained();
	endtask

	task automatic test_directed_corners();
		logic [FRAME_W-1:0] f;
		idle_on = 1'b1;
		cfg_write(REG_CHANNEL_COUNT, 16'd8);
		cfg_write(REG_ATTACK, 16'd0);
		cfg_write(REG_RELEASE, 16'd0);
		send_frame('0);
		send_frame(fill_frame(SAMPLE_MAX));
		send_frame(fill_frame(SAMPLE_MIN));
		for (int i = 0; i < NUM_CH; i++)
			f[i*SAMPLE_W +: SAMPLE_W] = i[0] ? SAMPLE_MIN : SAMPLE_MAX;
		send_frame(f);
		f = '0;
		f[(NUM_CH-1)*SAMPLE_W +: SAMPLE_W] = 16'sd30000;
		send_frame(f);
		send_frame(fill_frame(16'sd1));
		send_frame(fill_frame(-16'sd1));
		wait_drained();
		// zero threshold with zero ratio: divisor vanishes
		cfg_write(REG_THRESHOLD, 16'd0);
		cfg_write(REG_RATIO, 16'd0);
		send_frame(fill_frame(16'sd12345));
		send_frame('0);
		wait_drained();
		cfg_write(REG_RATIO, 16'hFFFF);
		send_frame(fill_frame(SAMPLE_MIN));
		wait_drained();
		// upper bit dropped on the threshold write
		cfg_write(REG_THRESHOLD, 16'hFFFF);
		send_frame(fill_frame(SAMPLE_MAX));
		wait_drained();
		cfg_write(REG_THRESHOLD, 16'd1);
		cfg_write(REG_ATTACK, 16'hFFFF);
		send_frame(fill_frame(SAMPLE_MAX));
		send_frame(fill_frame(16'sd20000));
		wait_drained();
		cfg_write(REG_CHANNEL_COUNT, 16'hFFF9);
		send_frame(noise_frame());
		wait_drained();
		cfg_write(REG_CHANNEL_COUNT, 16'd15);
		send_frame(noise_frame());
		wait_drained();
		cfg_write(REG_CHANNEL_COUNT, 16'd1);
		for (int idx = REG_RELEASE + 1; idx < (1 << CFG_IDX_W); idx++)
			cfg_write(idx[CFG_IDX_W-1:0], 16'h0003);
		send_frame(noise_frame());
		wait_drained();
		cfg_write(REG_CHANNEL_COUNT, 16'd0);
		send_frame(fill_frame(SAMPLE_MAX));
		wait_drained();
	endtask

	task automatic test_random_settings();
		logic [CFG_W-1:0] val;
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			if (ph == 0)
				val = 16'd8;
			else if ($urandom_range(0, 4) == 0)
				val = CFG_W'($urandom_range(0, 15));
			else
				val = CFG_W'($urandom_range(1, 8));
			cfg_write(REG_CHANNEL_COUNT, val | (16'($urandom_range(0, 1)) << 12));
			case (ph % 4)
				0: val = CFG_W'($urandom_range(1, 32767));
				1: val = 16'd1;
				2: val = 16'd32767;
				default: val = CFG_W'($urandom_range(8000, 30000));
			endcase
			cfg_write(REG_THRESHOLD, val | (16'($urandom_range(0, 1)) << 15));
			cfg_write(REG_RATIO, (ph == 3) ? 16'd0 : (ph == 5) ? 16'hFFFF : 16'($urandom()));
			cfg_write(REG_ATTACK, (ph == 1) ? 16'd0 : (ph == 4) ? 16'hFFFF : 16'($urandom()));
			cfg_write(REG_RELEASE, (ph == 2) ? 16'hFFFF : (ph == 6) ? 16'd0 : 16'($urandom()));
			idle_on = (ph != 5);
			send_program(62);
		end
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		cfg_write(REG_CHANNEL_COUNT, 16'd8);
		cfg_write(REG_THRESHOLD, 16'd16000);
		cfg_write(REG_ATTACK, 16'd20000);
		cfg_write(REG_RELEASE, 16'd60000);
		idle_on = 1'b0;
		hold_request = 1'b1;
		send_program(30);
		wait_drained();
	endtask

	task automatic test_streaming_no_idle();
		cfg_write(REG_RATIO, 16'($urandom()));
		idle_on = 1'b0;
		send_program(45);
		wait_drained();
	endtask

	initial begin
		chan_cnt = '0;
		thresh = THRESHOLD_RST;
		ratio = RATIO_RST;
		attack = '0;
		release_c = '0;
		env_level = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_directed_corners();
		test_random_settings();
		test_output_backpressure();
		test_streaming_no_idle();
		repeat (60) @(posedge clk);
		$display("Sent %0d frames and checked %0d output words across %0d register writes,",
			frames_sent, frames_checked, settings_used);
		$display("with random idling on both sides and one long output hold; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && pending_frames.size() == 0)
			$display("peak_envelope_audio_compressor test passed");
		else
			$display("peak_envelope_audio_compressor test failed");
		$finish;
	end

endmodule
